// ===== hdl/psup_pkg.sv =====
// Package for the power-fail supervisor: widths, codes and shared structs.
// Used by the sample and register-write interfaces and every module of the block.
package psup_pkg;

   localparam int TIME_W   = 32;
   localparam int SAMPLE_W = 32;
   localparam int CFG_W    = 16;
   localparam int INDEX_W  = 2;

   localparam logic [CFG_W-1:0] GRACE_DEFAULT = CFG_W'(5);

   typedef enum logic [1:0] {
      MODE_NORMAL  = 2'd0,
      MODE_FAIL    = 2'd1,
      MODE_RECOVER = 2'd2,
      MODE_HALTED  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STAT_READY   = 2'd0,
      STAT_LOST    = 2'd1,
      STAT_BATTERY = 2'd2,
      STAT_UNKNOWN = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      EV_NONE      = 3'd0,
      EV_LOST      = 3'd1,
      EV_RECOVERED = 3'd2,
      EV_TIMEOUT   = 3'd3,
      EV_BATTERY   = 3'd4,
      EV_READERR   = 3'd5,
      EV_BADSTAT   = 3'd6
   } event_type;

   typedef enum logic [INDEX_W-1:0] {
      REG_TIMEOUT_SECS = 2'd0,
      REG_GRACE_SECS   = 2'd1,
      REG_TEST_ONLY    = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [CFG_W-1:0] timeout_secs;
      logic [CFG_W-1:0] grace_secs;
      logic             test_only;
   } cfg_type;

   typedef struct packed {
      logic [1:0]          line_status;
      logic [SAMPLE_W-1:0] sample_time;
      logic                read_error;
   } item_type;

   typedef struct packed {
      logic [2:0] event_res;
      logic       sleep_ups;
      logic       halted;
      logic [1:0] power_state;
   } result_type;

endpackage

// ===== hdl/psup_ifs.sv =====
// Channel interfaces of the power-fail supervisor: sample, result, register write.
// Depends on psup_pkg.
interface psup_req_if;
   import psup_pkg::*;
   logic                valid;
   logic                ready;
   logic [1:0]          line_status;
   logic [SAMPLE_W-1:0] sample_time;
   logic                read_error;
   modport source (output valid, line_status, sample_time, read_error, input ready);
   modport sink (input valid, line_status, sample_time, read_error, output ready);
endinterface

interface psup_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] event_res;
   logic       sleep_ups;
   logic       halted;
   logic [1:0] power_state;
   modport source (output valid, event_res, sleep_ups, halted, power_state, input ready);
   modport sink (input valid, event_res, sleep_ups, halted, power_state, output ready);
endinterface

interface psup_csr_if;
   import psup_pkg::*;
   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] index;
   logic [CFG_W-1:0]   data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/power_fail_supervisor.sv =====
// Power-fail supervisor top level: register block and supervisor core.
// Depends on psup_pkg, the channel interfaces, psup_csr and psup_core.
//
// Usage:
//   req_bus carries one UPS status sample per transfer: line_status,
//   sample_time (seconds, wrapping) and read_error. rsp_bus returns exactly
//   one result per sample: event_res, sleep_ups, halted and power_state.
//   csr_bus writes the battery timeout (index 0), the grace period (index 1)
//   and test_only (index 2); csr_bus.ready is always high, other indexes are
//   dropped. Write registers only while no sample is in flight.
// Timing:
//   A sample sits in the sample register, where the state machine step runs;
//   its result is loaded into the result register once that one is free, and
//   rsp_bus.valid rises. One sample per cycle is sustained while rsp_bus.ready
//   stays high; the single state update per sample sets this rate. When
//   rsp_bus.ready is low the result holds, the sample register takes one more
//   sample if empty, then req_bus.ready drops until the result transfers.
// Reset:
//   Synchronous reset empties both registers, returns the machine to normal
//   with zero timestamps, and loads timeout 0, grace period 5, test_only 0.
//   Reset is also the only way out of the halted state.
module power_fail_supervisor (
   input  logic        clock,
   input  logic        reset,
   psup_req_if.sink    req_bus,
   psup_rsp_if.source  rsp_bus,
   psup_csr_if.sink    csr_bus
);
   import psup_pkg::*;

   cfg_type cfg;

   psup_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   psup_core u_core (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .cfg     (cfg)
   );

endmodule

// ===== hdl/psup_csr.sv =====
// Configuration registers of the power-fail supervisor.
// Depends on psup_pkg and psup_csr_if.
module psup_csr (
   input  logic              clock,
   input  logic              reset,
   psup_csr_if.sink          csr_bus,
   output psup_pkg::cfg_type cfg
);
   import psup_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    write;

   assign csr_bus.ready = 1'b1;
   assign write = csr_bus.valid & csr_bus.ready;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write) begin
         unique case (csr_bus.index)
            REG_TIMEOUT_SECS: cfg_in.timeout_secs = csr_bus.data;
            REG_GRACE_SECS:   cfg_in.grace_secs = csr_bus.data;
            REG_TEST_ONLY:    cfg_in.test_only = csr_bus.data[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_secs <= '0;
         cfg_ff.grace_secs   <= GRACE_DEFAULT;
         cfg_ff.test_only    <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hdl/psup_core.sv =====
// Sample register, supervisor state machine and result register.
// Depends on psup_pkg, psup_req_if and psup_rsp_if.
module psup_core (
   input  logic              clock,
   input  logic              reset,
   psup_req_if.sink          req_bus,
   psup_rsp_if.source        rsp_bus,
   input  psup_pkg::cfg_type cfg
);
   import psup_pkg::*;

   item_type          item_ff;
   logic              item_valid_ff;
   logic              item_valid_in;
   result_type        res_ff;
   result_type        res_in;
   logic              res_valid_ff;
   logic              res_valid_in;
   mode_type          mode_ff;
   mode_type          mode_in;
   logic [TIME_W-1:0] fail_start_ff;
   logic [TIME_W-1:0] fail_start_in;
   logic [TIME_W-1:0] recover_start_ff;
   logic [TIME_W-1:0] recover_start_in;
   logic [TIME_W-1:0] now;
   logic [TIME_W-1:0] fail_elapsed;
   logic [TIME_W-1:0] recover_elapsed;
   status_type        status;
   event_type         ev;
   logic              sleep;
   logic              accept;
   logic              advance;

   assign advance = item_valid_ff & (~res_valid_ff | rsp_bus.ready);
   assign req_bus.ready = ~item_valid_ff | advance;
   assign accept = req_bus.valid & req_bus.ready;
   assign item_valid_in = accept | (item_valid_ff & ~advance);
   assign res_valid_in = advance | (res_valid_ff & ~rsp_bus.ready);

   assign status = status_type'(item_ff.line_status);
   assign now = TIME_W'(item_ff.sample_time);
   assign fail_elapsed = now - fail_start_ff;
   assign recover_elapsed = now - recover_start_ff;

   always_comb begin
      mode_in = mode_ff;
      fail_start_in = fail_start_ff;
      recover_start_in = recover_start_ff;
      ev = EV_NONE;
      sleep = 1'b0;
      priority if (mode_ff == MODE_HALTED) begin
         mode_in = MODE_HALTED;
      end else if (item_ff.read_error) begin
         ev = EV_READERR;
         mode_in = MODE_HALTED;
      end else if (mode_ff == MODE_NORMAL) begin
         unique case (status)
            STAT_READY: ev = EV_NONE;
            STAT_LOST: begin
               mode_in = MODE_FAIL;
               fail_start_in = now;
               ev = EV_LOST;
            end
            default: begin
               ev = EV_BADSTAT;
               mode_in = MODE_HALTED;
            end
         endcase
      end else if (mode_ff == MODE_FAIL) begin
         unique case (status)
            STAT_READY: begin
               mode_in = MODE_RECOVER;
               recover_start_in = now;
            end
            STAT_LOST: begin
               if ((cfg.timeout_secs != '0) && (fail_elapsed > TIME_W'(cfg.timeout_secs))) begin
                  ev = EV_TIMEOUT;
                  sleep = ~cfg.test_only;
                  mode_in = MODE_HALTED;
               end
            end
            STAT_BATTERY: begin
               ev = EV_BATTERY;
               sleep = ~cfg.test_only;
               mode_in = MODE_HALTED;
            end
            default: begin
               ev = EV_BADSTAT;
               mode_in = MODE_HALTED;
            end
         endcase
      end else begin
         unique case (status)
            STAT_READY: begin
               if (recover_elapsed > TIME_W'(cfg.grace_secs)) begin
                  ev = EV_RECOVERED;
                  mode_in = MODE_NORMAL;
                  fail_start_in = '0;
                  recover_start_in = '0;
               end
            end
            STAT_LOST: mode_in = MODE_FAIL;
            default: begin
               ev = EV_BADSTAT;
               mode_in = MODE_HALTED;
            end
         endcase
      end
   end

   always_comb begin
      res_in.event_res = ev;
      res_in.sleep_ups = sleep;
      res_in.halted = (mode_in == MODE_HALTED);
      res_in.power_state = mode_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         res_valid_ff <= 1'b0;
         mode_ff <= MODE_NORMAL;
         fail_start_ff <= '0;
         recover_start_ff <= '0;
      end else begin
         item_valid_ff <= item_valid_in;
         res_valid_ff <= res_valid_in;
         if (advance) begin
            mode_ff <= mode_in;
            fail_start_ff <= fail_start_in;
            recover_start_ff <= recover_start_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.line_status <= req_bus.line_status;
         item_ff.sample_time <= req_bus.sample_time;
         item_ff.read_error <= req_bus.read_error;
      end
      if (advance) begin
         res_ff <= res_in;
      end
   end

   assign rsp_bus.valid = res_valid_ff;
   assign rsp_bus.event_res = res_ff.event_res;
   assign rsp_bus.sleep_ups = res_ff.sleep_ups;
   assign rsp_bus.halted = res_ff.halted;
   assign rsp_bus.power_state = res_ff.power_state;

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_HALTED |=> mode_ff == MODE_HALTED)
      else $error("supervisor left the halted state");

   a_halt_flag: assert property (@(posedge clock) disable iff (reset)
      res_valid_ff |-> (res_ff.halted == (res_ff.power_state == MODE_HALTED)))
      else $error("halted flag disagrees with power state");

   a_sleep_event: assert property (@(posedge clock) disable iff (reset)
      res_valid_ff && res_ff.sleep_ups |->
         (res_ff.event_res == EV_TIMEOUT || res_ff.event_res == EV_BATTERY))
      else $error("sleep request without a shutdown event");

   a_advance_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> res_valid_ff)
      else $error("advanced sample produced no result");

endmodule

// ===== tb/tb_power_fail_supervisor.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for power_fail_supervisor: directed and random UPS samples
// with random stalls on both channels, checked against an in-bench state machine model.
// Depends on psup_pkg, the channel interfaces in psup_ifs.sv and the block itself.
module tb_power_fail_supervisor;
   import psup_pkg::*;

   localparam int CYCLE_LIMIT   = 300000;
   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_CYCLES  = 8;
   localparam int PHASE_ITEMS   = 275;
   localparam int REPORT_MAX    = 40;
   localparam logic [INDEX_W-1:0] REG_UNUSED = 2'd3;

   typedef enum int {
      HALT_READ_ERROR,
      HALT_NORMAL_BAD,
      HALT_FAIL_UNKNOWN,
      HALT_FAIL_BATTERY,
      HALT_FAIL_TIMEOUT,
      HALT_RECOVER_BAD
   } halt_cause_type;

   logic clock = 1'b0;
   logic reset;

   psup_req_if req_bus();
   psup_rsp_if rsp_bus();
   psup_csr_if csr_bus();

   power_fail_supervisor u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   mode_type          sup_mode;
   logic [TIME_W-1:0] fail_t0;
   logic [TIME_W-1:0] recover_t0;
   logic [CFG_W-1:0]  cfg_timeout_secs;
   logic [CFG_W-1:0]  cfg_grace;
   logic              cfg_test_only;

   result_type expected_results[$];
   int         error_count = 0;
   int         cycle_count = 0;
   bit         send_calm   = 1'b0;
   bit         recv_calm   = 1'b0;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic result_type advance_supervisor(item_type it);
      result_type        r;
      logic [TIME_W-1:0] span;
      r = '0;
      if (sup_mode == MODE_HALTED) begin
      end else if (it.read_error) begin
         r.event_res = EV_READERR;
         sup_mode = MODE_HALTED;
      end else begin
         case (sup_mode)
            MODE_NORMAL: begin
               if (it.line_status == STAT_LOST) begin
                  sup_mode = MODE_FAIL;
                  fail_t0 = it.sample_time;
                  r.event_res = EV_LOST;
               end else if (it.line_status != STAT_READY) begin
                  r.event_res = EV_BADSTAT;
                  sup_mode = MODE_HALTED;
               end
            end
            MODE_FAIL: begin
               case (it.line_status)
                  STAT_READY: begin
                     sup_mode = MODE_RECOVER;
                     recover_t0 = it.sample_time;
                  end
                  STAT_LOST: begin
                     span = it.sample_time - fail_t0;
                     if (cfg_timeout_secs != 0 && span > cfg_timeout_secs) begin
                        r.event_res = EV_TIMEOUT;
                        r.sleep_ups = ~cfg_test_only;
                        sup_mode = MODE_HALTED;
                     end
                  end
                  STAT_BATTERY: begin
                     r.event_res = EV_BATTERY;
                     r.sleep_ups = ~cfg_test_only;
                     sup_mode = MODE_HALTED;
                  end
                  default: begin
                     r.event_res = EV_BADSTAT;
                     sup_mode = MODE_HALTED;
                  end
               endcase
            end
            default: begin
               if (it.line_status == STAT_READY) begin
                  span = it.sample_time - recover_t0;
                  if (span > cfg_grace) begin
                     r.event_res = EV_RECOVERED;
                     sup_mode = MODE_NORMAL;
                     fail_t0 = '0;
                     recover_t0 = '0;
                  end
               end else if (it.line_status == STAT_LOST) begin
                  sup_mode = MODE_FAIL;
               end else begin
                  r.event_res = EV_BADSTAT;
                  sup_mode = MODE_HALTED;
               end
            end
         endcase
      end
      r.halted = (sup_mode == MODE_HALTED);
      r.power_state = sup_mode;
      return r;
   endfunction

   function automatic item_type make_sample(logic [1:0] status, logic [TIME_W-1:0] t,
                                            logic err);
      item_type s;
      s.line_status = status;
      s.sample_time = t;
      s.read_error = err;
      return s;
   endfunction

   // Well-formed traffic: never halts, leans on the timeout and grace boundaries.
   function automatic item_type next_sample();
      logic [TIME_W-1:0] t;
      logic [TIME_W-1:0] span;
      t = $urandom;
      span = '0;
      case (sup_mode)
         MODE_NORMAL: begin
            if ($urandom_range(0, 9) < 4) return make_sample(STAT_LOST, t, 1'b0);
            return make_sample(STAT_READY, t, 1'b0);
         end
         MODE_FAIL: begin
            if ($urandom_range(0, 1)) return make_sample(STAT_READY, t, 1'b0);
            if (cfg_timeout_secs == 0) return make_sample(STAT_LOST, t, 1'b0);
            case ($urandom_range(0, 3))
               0: span = TIME_W'(cfg_timeout_secs);
               1: span = '0;
               default: span = $urandom_range(0, cfg_timeout_secs);
            endcase
            return make_sample(STAT_LOST, fail_t0 + span, 1'b0);
         end
         default: begin
            if ($urandom_range(0, 9) < 4) return make_sample(STAT_LOST, t, 1'b0);
            case ($urandom_range(0, 4))
               0: span = TIME_W'(cfg_grace);
               1: span = cfg_grace + 1;
               2: span = $urandom_range(0, cfg_grace);
               3: span = $urandom;
               default: span = cfg_grace + $urandom_range(1, 16);
            endcase
            return make_sample(STAT_READY, recover_t0 + span, 1'b0);
         end
      endcase
   endfunction

   task automatic report_mismatch(string msg);
      error_count++;
      if (error_count <= REPORT_MAX) $display("mismatch at cycle %0d: %s", cycle_count, msg);
   endtask

   task automatic compare_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
   endtask

   task automatic send_sample(item_type it);
      int gap;
      if ($urandom_range(0, 31) == 0) send_calm = !send_calm;
      gap = send_calm ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.line_status <= it.line_status;
      req_bus.sample_time <= it.sample_time;
      req_bus.read_error <= it.read_error;
      do @(posedge clock); while (!req_bus.ready);
      expected_results.push_back(advance_supervisor(it));
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [INDEX_W-1:0] idx, logic [CFG_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= value;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         REG_TIMEOUT_SECS: cfg_timeout_secs = value;
         REG_GRACE_SECS:   cfg_grace = value;
         REG_TEST_ONLY:    cfg_test_only = value[0];
         default: ;
      endcase
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_settings(logic [CFG_W-1:0] timeout, logic [CFG_W-1:0] grace,
                                 logic test);
      wait_idle();
      write_reg(REG_TIMEOUT_SECS, timeout);
      write_reg(REG_GRACE_SECS, grace);
      write_reg(REG_TEST_ONLY, {15'($urandom), test});
   endtask

   task automatic steer_to(mode_type target);
      while (sup_mode != target) begin
         case (sup_mode)
            MODE_NORMAL: send_sample(make_sample(STAT_LOST, $urandom, 1'b0));
            MODE_FAIL:   send_sample(make_sample(STAT_READY, $urandom, 1'b0));
            default: begin
               if (target == MODE_FAIL) send_sample(make_sample(STAT_LOST, $urandom, 1'b0));
               else send_sample(make_sample(STAT_READY, recover_t0 + cfg_grace + 1, 1'b0));
            end
         endcase
      end
   endtask

   // Reset settings: wrapping timestamps, relapse and recovery exactly past grace.
   task automatic test_directed_wrap();
      send_sample(make_sample(STAT_READY, 32'h0000_0000, 1'b0));
      send_sample(make_sample(STAT_READY, 32'hFFFF_FFFF, 1'b0));
      send_sample(make_sample(STAT_LOST,  32'hFFFF_FFF0, 1'b0));
      send_sample(make_sample(STAT_LOST,  32'h0000_0010, 1'b0));
      send_sample(make_sample(STAT_READY, 32'hFFFF_FFFE, 1'b0));
      send_sample(make_sample(STAT_READY, 32'h0000_0003, 1'b0));
      send_sample(make_sample(STAT_LOST,  32'h0000_0004, 1'b0));
      send_sample(make_sample(STAT_READY, 32'h0000_0100, 1'b0));
      send_sample(make_sample(STAT_READY, 32'h0000_0106, 1'b0));
      send_sample(make_sample(STAT_LOST,  32'h0000_0000, 1'b0));
      send_sample(make_sample(STAT_READY, 32'h0000_0000, 1'b0));
      send_sample(make_sample(STAT_READY, 32'h0000_0000, 1'b0));
      send_sample(make_sample(STAT_READY, 32'h0000_0006, 1'b0));
   endtask

   // Register extremes: longest timeout with zero grace, shortest timeout with longest grace.
   task automatic test_directed_limits();
      apply_settings(16'hFFFF, 16'h0000, 1'b1);
      send_sample(make_sample(STAT_LOST,  32'h7FFF_FFFF, 1'b0));
      send_sample(make_sample(STAT_LOST,  32'h8000_FFFE, 1'b0));
      send_sample(make_sample(STAT_READY, 32'h8001_0000, 1'b0));
      send_sample(make_sample(STAT_READY, 32'h8001_0000, 1'b0));
      send_sample(make_sample(STAT_READY, 32'h8001_0001, 1'b0));
      apply_settings(16'h0001, 16'hFFFF, 1'b0);
      write_reg(REG_UNUSED, 16'($urandom));
      send_sample(make_sample(STAT_LOST,  32'd100, 1'b0));
      send_sample(make_sample(STAT_LOST,  32'd101, 1'b0));
      send_sample(make_sample(STAT_READY, 32'd101, 1'b0));
      send_sample(make_sample(STAT_READY, 32'd101 + 32'd65535, 1'b0));
      send_sample(make_sample(STAT_READY, 32'd101 + 32'd65536, 1'b0));
   endtask

   task automatic test_random_traffic();
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: apply_settings(16'h0000, GRACE_DEFAULT, 1'b0);
            1: apply_settings(16'hFFFF, 16'hFFFF, 1'b1);
            2: apply_settings(16'h0001, 16'h0001, 1'b0);
            3: apply_settings(16'h0000, 16'h0000, 1'b1);
            4: apply_settings(16'($urandom), 16'($urandom), 1'($urandom));
            default: apply_settings(16'($urandom_range(1, 40)), 16'($urandom_range(0, 10)),
                                    1'($urandom));
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 2 && n == PHASE_ITEMS / 2) wait_idle();
            send_sample(next_sample());
         end
      end
   endtask

   // One halting event, then samples that the halted block must ignore.
   task automatic test_halt_and_ignore();
      halt_cause_type cause;
      cause = halt_cause_type'($urandom_range(0, 5));
      apply_settings(16'($urandom_range(1, 65535)), 16'($urandom), 1'($urandom));
      case (cause)
         HALT_READ_ERROR: begin
            steer_to(mode_type'($urandom_range(0, 2)));
            send_sample(make_sample(2'($urandom_range(0, 3)), $urandom, 1'b1));
         end
         HALT_NORMAL_BAD: begin
            steer_to(MODE_NORMAL);
            send_sample(make_sample(2'($urandom_range(2, 3)), $urandom, 1'b0));
         end
         HALT_FAIL_UNKNOWN: begin
            steer_to(MODE_FAIL);
            send_sample(make_sample(STAT_UNKNOWN, $urandom, 1'b0));
         end
         HALT_FAIL_BATTERY: begin
            steer_to(MODE_FAIL);
            send_sample(make_sample(STAT_BATTERY, $urandom, 1'b0));
         end
         HALT_FAIL_TIMEOUT: begin
            steer_to(MODE_FAIL);
            send_sample(make_sample(STAT_LOST,
                                    fail_t0 + cfg_timeout_secs + $urandom_range(1, 1000), 1'b0));
         end
         default: begin
            steer_to(MODE_RECOVER);
            send_sample(make_sample(2'($urandom_range(2, 3)), $urandom, 1'b0));
         end
      endcase
      for (int n = 0; n < 24; n++)
         send_sample(make_sample(2'($urandom_range(0, 3)), $urandom, 1'($urandom)));
   endtask

   initial begin : result_checker
      int         hold;
      result_type want;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if ($urandom_range(0, 31) == 0) recv_calm = !recv_calm;
         hold = recv_calm ? 0 : $urandom_range(0, 13);
         if (hold > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
         if (expected_results.size() == 0) begin
            report_mismatch("result transfer with nothing expected");
         end else begin
            want = expected_results.pop_front();
            compare_field("event_res", 8'(rsp_bus.event_res), 8'(want.event_res));
            compare_field("sleep_ups", 8'(rsp_bus.sleep_ups), 8'(want.sleep_ups));
            compare_field("halted", 8'(rsp_bus.halted), 8'(want.halted));
            compare_field("power_state", 8'(rsp_bus.power_state), 8'(want.power_state));
         end
      end
   end

   initial begin
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.line_status <= '0;
      req_bus.sample_time <= '0;
      req_bus.read_error <= 1'b0;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= '0;
      csr_bus.data <= '0;
      sup_mode = MODE_NORMAL;
      fail_t0 = '0;
      recover_t0 = '0;
      cfg_timeout_secs = '0;
      cfg_grace = GRACE_DEFAULT;
      cfg_test_only = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed_wrap();
      test_directed_limits();
      test_random_traffic();
      test_halt_and_ignore();
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/psup_pkg.sv
hdl/psup_ifs.sv
hdl/psup_csr.sv
hdl/psup_core.sv
hdl/power_fail_supervisor.sv
tb/tb_power_fail_supervisor.sv
